>>> design/lu8cd_pkg.sv
`default_nettype none

package lu8cd_pkg;

	localparam int unsigned PendDepth = 5;

	localparam logic [7:0] ContMask    = 8'hC0;
	localparam logic [7:0] ContPattern = 8'h80;
	localparam logic [7:0] SixBitMask  = 8'h3F;

	typedef logic [2:0] len_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [30:0] code_point;
		logic [2:0]  byte_count;
		logic        malformed;
		logic [15:0] char_total;
		logic        final_char;
	} out_item_t;

	typedef logic [PendDepth-1:0][7:0] pend_t;

	// Decision for the transaction that sits in the input register.
	typedef struct packed {
		logic        need_flush;
		logic        has_tail;
		logic        buffer_byte;
		logic        append_byte;
		len_t        new_exp;
		logic [30:0] tail_cp;
		len_t        tail_count;
		logic        tail_bad;
	} step_t;

	function automatic len_t lead_length(input logic [7:0] b);
		len_t n;
		n = 3'd0;
		if ((b & 8'h80) == 8'h00) begin
			n = 3'd1;
		end else if ((b & 8'hE0) == 8'hC0) begin
			n = 3'd2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			n = 3'd3;
		end else if ((b & 8'hF8) == 8'hF0) begin
			n = 3'd4;
		end else if ((b & 8'hFC) == 8'hF8) begin
			n = 3'd5;
		end else if ((b & 8'hFE) == 8'hFC) begin
			n = 3'd6;
		end
		return n;
	endfunction

	function automatic logic [7:0] lead_mask(input len_t n);
		logic [7:0] m;
		unique case (n)
			3'd1: m = 8'h7F;
			3'd2: m = 8'h1F;
			3'd3: m = 8'h0F;
			3'd4: m = 8'h07;
			3'd5: m = 8'h03;
			3'd6: m = 8'h01;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> design/lu8cd_tail.sv
`default_nettype none

module lu8cd_tail (
	input  lu8cd_pkg::in_item_t item,
	input  lu8cd_pkg::len_t     pend_len,
	input  lu8cd_pkg::len_t     exp_len,
	input  lu8cd_pkg::pend_t    pend,
	output lu8cd_pkg::step_t    step
);

	always_comb begin
		logic [7:0]       b;
		logic             eot;
		lu8cd_pkg::len_t  lead_n;
		logic             cont;
		logic             app;
		logic             complete;
		logic [5:0][7:0]  full;
		logic [30:0]      value;
		logic [30:0]      raw_cp;

		b        = item.data_byte;
		eot      = item.end_of_text;
		lead_n   = lu8cd_pkg::lead_length(b);
		cont     = (b & lu8cd_pkg::ContMask) == lu8cd_pkg::ContPattern;
		app      = (pend_len != 3'd0) && cont;
		complete = app && (({1'b0, pend_len} + 4'd1) >= {1'b0, exp_len});
		raw_cp   = {23'd0, b};

		for (int i = 0; i < 6; i++) begin
			if (i < lu8cd_pkg::PendDepth && i < int'(pend_len)) begin
				full[i] = pend[i];
			end else begin
				full[i] = b;
			end
		end

		value = {23'd0, full[0] & lu8cd_pkg::lead_mask(exp_len)};
		for (int i = 1; i < 6; i++) begin
			if (i < int'(exp_len)) begin
				value = {value[24:0], full[i][5:0] & lu8cd_pkg::SixBitMask[5:0]};
			end
		end

		step             = '0;
		step.need_flush  = (pend_len != 3'd0) && (!cont || (!complete && eot));
		step.new_exp     = lead_n;
		step.tail_cp     = raw_cp;
		step.tail_count  = 3'd1;
		step.tail_bad    = 1'b1;

		priority if (app) begin
			if (complete) begin
				step.has_tail   = 1'b1;
				step.tail_cp    = value;
				step.tail_count = exp_len;
				step.tail_bad   = 1'b0;
			end else if (eot) begin
				step.has_tail = 1'b1;
			end else begin
				step.append_byte = 1'b1;
			end
		end else if (lead_n == 3'd0) begin
			step.has_tail = 1'b1;
		end else if (lead_n == 3'd1) begin
			step.has_tail = 1'b1;
			step.tail_bad = 1'b0;
		end else if (eot) begin
			step.has_tail = 1'b1;
		end else begin
			step.buffer_byte = 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> design/lax_utf8_char_decoder.sv
// Lax UTF-8 character decoder, legacy one-to-six-byte form.
// Input channel byte_valid/byte_ready/byte_data carries one string byte per
// transaction, with end_of_text set on the last byte of a string. Output
// channel char_valid/char_ready/char_data carries one character per
// transaction: code point, bytes consumed, malformed flag, running count and
// a final_char flag on the last character of the string.
// A byte is taken into an input register; its result is loaded into the
// output register once the output is free, and the character is delivered
// from there. Well-formed text runs at one byte per cycle while the receiver
// does not stall. When a sequence breaks off, or a string ends inside a
// sequence, the bytes buffered so far (at most five) come out raw one per cycle
// while the receiver keeps up, and the input is held until they are all out.
// Reset clears the buffered sequence, the character count and both valid
// flags. When the receiver stalls, the result waits in the output register
// while the next byte is still taken and decoded; the block then holds
// byte_ready low only once that byte itself has a result to deliver.
`default_nettype none

module lax_utf8_char_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  lu8cd_pkg::in_item_t   byte_data,
	output logic                  char_valid,
	input  logic                  char_ready,
	output lu8cd_pkg::out_item_t  char_data
);

	lu8cd_pkg::in_item_t  item_s1;
	logic                 item_valid_s1;
	lu8cd_pkg::pend_t     pend_q;
	lu8cd_pkg::len_t      pend_len_q;
	lu8cd_pkg::len_t      exp_len_q;
	lu8cd_pkg::len_t      fidx_q;
	logic [15:0]          char_cnt_q;
	logic                 out_valid_q;
	lu8cd_pkg::out_item_t out_q;

	lu8cd_pkg::step_t     step;
	lu8cd_pkg::out_item_t result;
	logic                 flush_phase;
	logic                 emits;
	logic                 out_free;
	logic                 go;
	logic                 retire;
	logic                 load;
	logic                 ld_final;
	logic [15:0]          cnt_inc;

	lu8cd_tail u_tail (
		.item     (item_s1),
		.pend_len (pend_len_q),
		.exp_len  (exp_len_q),
		.pend     (pend_q),
		.step     (step)
	);

	assign flush_phase = step.need_flush && (fidx_q != pend_len_q);
	assign emits       = item_valid_s1 && (flush_phase || step.has_tail);
	assign out_free    = !out_valid_q || char_ready;
	assign go          = item_valid_s1 && (out_free || !emits);
	assign retire      = go && !flush_phase;
	assign load        = go && emits;
	assign ld_final    = retire && step.has_tail && item_s1.end_of_text;
	assign byte_ready  = !item_valid_s1 || retire;
	assign cnt_inc     = (char_cnt_q == 16'hFFFF) ? char_cnt_q : char_cnt_q + 16'd1;

	always_comb begin
		result            = '0;
		result.char_total = cnt_inc;
		if (flush_phase) begin
			result.code_point = {23'd0, pend_q[fidx_q]};
			result.byte_count = 3'd1;
			result.malformed  = 1'b1;
		end else begin
			result.code_point = step.tail_cp;
			result.byte_count = step.tail_count;
			result.malformed  = step.tail_bad;
			result.final_char = item_s1.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			fidx_q        <= 3'd0;
			pend_len_q    <= 3'd0;
			exp_len_q     <= 3'd0;
			char_cnt_q    <= 16'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (byte_ready) begin
				item_valid_s1 <= byte_valid;
			end
			if (go) begin
				fidx_q <= flush_phase ? fidx_q + 3'd1 : 3'd0;
			end
			if (retire) begin
				if (step.buffer_byte) begin
					pend_len_q <= 3'd1;
					exp_len_q  <= step.new_exp;
				end else if (step.append_byte) begin
					pend_len_q <= pend_len_q + 3'd1;
				end else begin
					pend_len_q <= 3'd0;
					exp_len_q  <= 3'd0;
				end
			end
			if (ld_final) begin
				char_cnt_q <= 16'd0;
			end else if (load) begin
				char_cnt_q <= cnt_inc;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_data;
		end
		if (retire && step.buffer_byte) begin
			pend_q[0] <= item_s1.data_byte;
		end else if (retire && step.append_byte) begin
			pend_q[pend_len_q] <= item_s1.data_byte;
		end
		if (load) begin
			out_q <= result;
		end
	end

	assign char_valid = out_valid_q;
	assign char_data  = out_q;

	a_pend_shorter: assert property (@(posedge clk) disable iff (!arst_n)
		pend_len_q != 3'd0 |-> exp_len_q > pend_len_q)
		else $error("Buffered sequence is not shorter than its announced length.");

	a_fidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q != 3'd0 |-> item_valid_s1 && fidx_q <= pend_len_q)
		else $error("Flush index runs past the buffered bytes.");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ld_final |=> char_cnt_q == 16'd0 && pend_len_q == 3'd0)
		else $error("End of string left count or buffered bytes behind.");

	a_flush_raw: assert property (@(posedge clk) disable iff (!arst_n)
		load && flush_phase |=> out_q.malformed && out_q.byte_count == 3'd1
			&& !out_q.final_char)
		else $error("Flushed byte was not delivered as a raw transaction.");

endmodule

`default_nettype wire

>>> tb/sv/lax_utf8_char_decoder_tb.sv
`default_nettype none

module lax_utf8_char_decoder_tb;

	localparam int QuietLimit = 2000;
	localparam int HoldCycles = 80;
	localparam int IdlePct = 21;
	localparam int RandomBytes = 134;
	localparam logic [15:0] CountFull = 16'hFFFF;

	typedef struct packed {
		logic [7:0]            data;
		logic                  eot;
		logic                  typed;
		lu8cd_pkg::out_item_t  want;
	} row_t;

	localparam lu8cd_pkg::out_item_t NoChar = '0;

	localparam row_t Directed [26] = '{
		'{8'h41, 1'b0, 1'b1, '{31'h41, 3'd1, 1'b0, 16'd1, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{31'h7F, 3'd1, 1'b0, 16'd2, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{31'h80, 3'd1, 1'b1, 16'd3, 1'b0}},
		'{8'hFE, 1'b0, 1'b1, '{31'hFE, 3'd1, 1'b1, 16'd4, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{31'hFF, 3'd1, 1'b1, 16'd5, 1'b1}},
		'{8'h01, 1'b1, 1'b1, '{31'h01, 3'd1, 1'b0, 16'd1, 1'b1}},
		'{8'hC0, 1'b1, 1'b1, '{31'hC0, 3'd1, 1'b1, 16'd1, 1'b1}},
		'{8'hC3, 1'b0, 1'b0, NoChar},
		'{8'hA9, 1'b0, 1'b0, NoChar},
		'{8'hE2, 1'b0, 1'b0, NoChar},
		'{8'h82, 1'b0, 1'b0, NoChar},
		'{8'hAC, 1'b0, 1'b0, NoChar},
		'{8'hFD, 1'b0, 1'b0, NoChar},
		'{8'hBF, 1'b0, 1'b0, NoChar},
		'{8'hBF, 1'b0, 1'b0, NoChar},
		'{8'hBF, 1'b0, 1'b0, NoChar},
		'{8'hBF, 1'b0, 1'b0, NoChar},
		'{8'hBF, 1'b0, 1'b0, NoChar},
		'{8'hFC, 1'b0, 1'b0, NoChar},
		'{8'h80, 1'b0, 1'b0, NoChar},
		'{8'h80, 1'b0, 1'b0, NoChar},
		'{8'h80, 1'b0, 1'b0, NoChar},
		'{8'h80, 1'b0, 1'b0, NoChar},
		'{8'h00, 1'b0, 1'b0, NoChar},
		'{8'hE2, 1'b0, 1'b0, NoChar},
		'{8'h82, 1'b1, 1'b0, NoChar}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_ready;
	lu8cd_pkg::in_item_t   byte_data;
	logic                  char_valid;
	logic                  char_ready;
	lu8cd_pkg::out_item_t  char_data;

	logic idle_on = 1'b1;
	logic hold_now = 1'b0;
	int   errors = 0;
	int   quiet = 0;

	logic [7:0]            seq_bytes [6] = '{default: 8'h00};
	int unsigned           seq_len = 0;
	int unsigned           seq_need = 0;
	logic [15:0]           run_count = '0;
	lu8cd_pkg::out_item_t  step_chars [$];
	lu8cd_pkg::out_item_t  want_q [$];

	lax_utf8_char_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned lead_len(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			8'b111110??: return 5;
			8'b1111110?: return 6;
			default: return 0;
		endcase
	endfunction

	function automatic void put_char(input logic [30:0] cp, input logic [2:0] n,
			input logic bad);
		lu8cd_pkg::out_item_t c;
		if (run_count != CountFull) begin
			run_count++;
		end
		c.code_point = cp;
		c.byte_count = n;
		c.malformed = bad;
		c.char_total = run_count;
		c.final_char = 1'b0;
		step_chars.push_back(c);
	endfunction

	function automatic void flush_pending();
		for (int unsigned i = 0; i < seq_len; i++) begin
			put_char({23'd0, seq_bytes[i]}, 3'd1, 1'b1);
		end
		seq_len = 0;
		seq_need = 0;
	endfunction

	function automatic void begin_char(input logic [7:0] b);
		int unsigned n;
		n = lead_len(b);
		if (n == 0) begin
			put_char({23'd0, b}, 3'd1, 1'b1);
		end else if (n == 1) begin
			put_char({23'd0, b}, 3'd1, 1'b0);
		end else begin
			seq_bytes[0] = b;
			seq_len = 1;
			seq_need = n;
		end
	endfunction

	function automatic logic [30:0] assemble_char();
		logic [31:0] v;
		v = seq_bytes[0] & (32'hFF >> (seq_need + 1));
		for (int unsigned i = 1; i < seq_need; i++) begin
			v = (v << 6) | (seq_bytes[i] & lu8cd_pkg::SixBitMask);
		end
		return v[30:0];
	endfunction

	// Leaves the characters caused by one byte in step_chars.
	function automatic void decode_byte(input lu8cd_pkg::in_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		step_chars.delete();
		if (seq_len == 0) begin
			begin_char(b);
		end else if ((b & lu8cd_pkg::ContMask) == lu8cd_pkg::ContPattern) begin
			seq_bytes[seq_len] = b;
			seq_len++;
			if (seq_len >= seq_need) begin
				put_char(assemble_char(), 3'(seq_need), 1'b0);
				seq_len = 0;
				seq_need = 0;
			end
		end else begin
			flush_pending();
			begin_char(b);
		end
		if (it.end_of_text) begin
			flush_pending();
			if (step_chars.size() > 0) begin
				step_chars[step_chars.size() - 1].final_char = 1'b1;
			end
			run_count = '0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
			input lu8cd_pkg::out_item_t want);
		lu8cd_pkg::in_item_t it;
		it.data_byte = b;
		it.end_of_text = eot;
		while (idle_on && $urandom_range(99) < IdlePct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		@(posedge clk);
		while (!byte_ready) begin
			@(posedge clk);
		end
		decode_byte(it);
		if (typed) begin
			want_q.push_back(want);
		end else begin
			foreach (step_chars[i]) begin
				want_q.push_back(step_chars[i]);
			end
		end
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'(lu8cd_pkg::ContPattern | ($urandom & lu8cd_pkg::SixBitMask));
	endfunction

	function automatic logic [7:0] lead_byte(input int unsigned n);
		case (n)
			1: return 8'($urandom & 8'h7F);
			2: return 8'(8'hC0 | ($urandom & 8'h1F));
			3: return 8'(8'hE0 | ($urandom & 8'h0F));
			4: return 8'(8'hF0 | ($urandom & 8'h07));
			5: return 8'(8'hF8 | ($urandom & 8'h03));
			default: return 8'(8'hFC | ($urandom & 8'h01));
		endcase
	endfunction

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		lu8cd_pkg::out_item_t want;
		if (arst_n && char_valid && char_ready) begin
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: no character expected, got code point %0h",
					$time, char_data.code_point);
			end else begin
				want = want_q.pop_front();
				field_check("code_point", 32'(want.code_point), 32'(char_data.code_point));
				field_check("byte_count", 32'(want.byte_count), 32'(char_data.byte_count));
				field_check("malformed", 32'(want.malformed), 32'(char_data.malformed));
				field_check("char_total", 32'(want.char_total), 32'(char_data.char_total));
				field_check("final_char", 32'(want.final_char), 32'(char_data.final_char));
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (char_valid && char_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QuietLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic held;
		held = 1'b0;
		char_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_now && !held) begin
				char_ready <= 1'b0;
				held = 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			char_ready <= !idle_on || ($urandom_range(99) >= IdlePct);
		end
	end

	initial begin
		logic [7:0]  seq [$];
		int          sent;
		int unsigned kind;
		int unsigned n;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (Directed[i]) begin
			send_byte(Directed[i].data, Directed[i].eot, Directed[i].typed, Directed[i].want);
		end

		// The first stretch of the random part runs with no idling on either side.
		sent = 0;
		idle_on <= 1'b0;
		while (sent < RandomBytes) begin
			if (sent >= 40 && !idle_on) begin
				idle_on <= 1'b1;
				hold_now <= 1'b1;
			end
			seq.delete();
			kind = $urandom_range(99);
			if (kind < 70) begin
				n = $urandom_range(1, 6);
				seq.push_back(lead_byte(n));
				repeat (n - 1) seq.push_back(cont_byte());
			end else if (kind < 85) begin
				n = $urandom_range(2, 6);
				seq.push_back(lead_byte(n));
				repeat ($urandom_range(0, n - 2)) seq.push_back(cont_byte());
				seq.push_back(lead_byte($urandom_range(1, 6)));
			end else begin
				seq.push_back(8'($urandom_range(0, 255)));
			end
			foreach (seq[i]) begin
				send_byte(seq[i], $urandom_range(99) < 8, 1'b0, NoChar);
				sent++;
			end
		end

		send_byte(lead_byte(1), 1'b1, 1'b0, NoChar);

		byte_valid <= 1'b0;
		while (want_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
